@@ rtl/integer_matrix_multiply_core_macros.svh @@
// Assertion macros shared by the matrix multiply RTL.
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/imm_pkg.sv @@
// Constants and helpers for the integer matrix multiply core.
package imm_pkg;

    localparam int MAX_SIDE = 8;
    localparam int SIDE_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 4;

    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] word_t;

    // Map the side register to side length minus one, clamped to 1..MAX_SIDE.
    function automatic side_t side_m1(input logic [CFG_W-1:0] n);
        side_t r;
        if (n == '0)
        begin
            r = '0;
        end
        else if (int'(n) > MAX_SIDE)
        begin
            r = SIDE_W'(MAX_SIDE - 1);
        end
        else
        begin
            r = SIDE_W'(n - 1'b1);
        end
        return r;
    endfunction

endpackage

@@ rtl/integer_matrix_multiply_core.sv @@
// Top level of the integer matrix multiply core: operand memories and MAC sequencer.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------
//   in       | in_valid / in_stall | a_value, b_value
//   out      | out_valid/out_stall | product_value, last_out
//   cfg      | cfg_valid/cfg_ready | n_used
//
// The core takes n*n load requests per matrix pair. For each result element,
// n reads of the single read port of each operand memory feed one multiplier
// and one accumulator, then the sum drains through the product and accumulator
// registers and is handed off to the output register; output stalls hold it.
// Reset clears control only; memory contents stay unknown until loaded.
// in_stall stays high from the last load request until the last result sits
// in the output register, and while a side write is offered, so the write
// always lands before a load request of the same cycle.
// A stalled output freezes the sequencer in drain.
module integer_matrix_multiply_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          a_value,
    input  logic signed [31:0]          b_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          product_value,
    output logic                        last_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [imm_pkg::CFG_W-1:0]   n_used
);

`include "integer_matrix_multiply_core_macros.svh"

    // Sequencer states
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]           state_reg, state_next;
    imm_pkg::side_t       side_m1_reg;

    // Load position within the current matrix pair
    imm_pkg::side_t       lrow_reg, lcol_reg;
    // Result position and inner index
    imm_pkg::side_t       row_reg, col_reg, k_reg;

    // Operand memories, one write and one read port each
    imm_pkg::word_t       mem_a [imm_pkg::DEPTH];
    imm_pkg::word_t       mem_b [imm_pkg::DEPTH];
    imm_pkg::word_t       rd_a_reg, rd_b_reg;

    // Pipeline tags: read data, product, finished sum
    logic                 rd_vld_reg, rd_first_reg, rd_last_reg;
    logic                 prod_vld_reg, prod_first_reg, prod_last_reg;
    imm_pkg::word_t       prod_reg;
    imm_pkg::word_t       acc_reg;
    logic                 res_done_reg;

    logic                 out_valid_reg, last_out_reg;
    imm_pkg::word_t       out_data_reg;

    logic                 in_accept, cfg_write, issue, out_free, out_load;
    logic                 load_last, elem_last, k_last;
    imm_pkg::addr_t       wr_addr, rd_addr_a, rd_addr_b;
    imm_pkg::word_t       mul_low;

    assign in_stall      = (state_reg != ST_LOAD) || cfg_valid;
    assign cfg_ready     = (state_reg == ST_LOAD);
    assign out_valid     = out_valid_reg;
    assign product_value = out_data_reg;
    assign last_out      = last_out_reg;

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign load_last = (lrow_reg == side_m1_reg) && (lcol_reg == side_m1_reg);
    assign k_last    = (k_reg == side_m1_reg);
    assign elem_last = (row_reg == side_m1_reg) && (col_reg == side_m1_reg);
    assign issue     = (state_reg == ST_MAC);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_DRAIN) && res_done_reg && out_free;

    // Stride MAX_SIDE addressing: element (r, c) lives at {r, c}
    assign wr_addr   = {lrow_reg, lcol_reg};
    assign rd_addr_a = {row_reg, k_reg};
    assign rd_addr_b = {k_reg, col_reg};

    // Low word of the product is the same for signed and unsigned operands
    assign mul_low = imm_pkg::DATA_W'(rd_a_reg * rd_b_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && load_last && !cfg_write)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    state_next = elem_last ? ST_LOAD : ST_MAC;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Memories: write on load requests; the registered read runs unconditionally and serves each MAC issue
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mem_a[wr_addr] <= a_value;
            mem_b[wr_addr] <= b_value;
        end
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= mul_low;
        end
        if (prod_vld_reg)
        begin
            acc_reg <= prod_first_reg ? prod_reg : acc_reg + prod_reg;
        end
        if (out_load)
        begin
            out_data_reg <= acc_reg;
            last_out_reg <= elem_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            side_m1_reg    <= imm_pkg::side_m1(imm_pkg::CFG_W'(imm_pkg::MAX_SIDE));
            lrow_reg       <= '0;
            lcol_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            rd_vld_reg     <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_vld_reg   <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            res_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Side change drops any partial load
            if (cfg_write)
            begin
                side_m1_reg <= imm_pkg::side_m1(n_used);
                lrow_reg    <= '0;
                lcol_reg    <= '0;
            end
            else if (in_accept)
            begin
                if (lcol_reg == side_m1_reg)
                begin
                    lcol_reg <= '0;
                    lrow_reg <= load_last ? '0 : lrow_reg + 1'b1;
                end
                else
                begin
                    lcol_reg <= lcol_reg + 1'b1;
                end
                if (load_last)
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    k_reg   <= '0;
                end
            end

            // Issue one read pair per cycle, advance k
            rd_vld_reg   <= issue;
            rd_first_reg <= (k_reg == '0);
            rd_last_reg  <= k_last;
            if (issue)
            begin
                k_reg <= k_last ? '0 : k_reg + 1'b1;
            end

            prod_vld_reg   <= rd_vld_reg;
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;

            // Hold the finished sum until the output register takes it
            if (prod_vld_reg && prod_last_reg)
            begin
                res_done_reg <= 1'b1;
            end
            else if (out_load)
            begin
                res_done_reg <= 1'b0;
            end

            // Advance to the next result element
            if (out_load)
            begin
                if (col_reg == side_m1_reg)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A read result only follows a MAC issue cycle
    `IMM_ASSERT_NOW(a_rd_after_issue, rd_vld_reg, $past(state_reg) == ST_MAC,
        "read data valid without a preceding issue")
    // A new sum never completes over one not yet handed off
    `IMM_ASSERT_NOW(a_no_overwrite, prod_vld_reg && prod_last_reg, !res_done_reg,
        "finished sum overwritten before hand-off")
    // Back in load, the MAC pipeline is empty
    `IMM_ASSERT_NOW(a_load_idle, state_reg == ST_LOAD,
        !rd_vld_reg && !prod_vld_reg && !res_done_reg,
        "MAC pipeline busy while loading")
    // Handing off the last element returns the sequencer to load
    `IMM_ASSERT_NEXT(a_last_to_load, out_load && elem_last, state_reg == ST_LOAD,
        "sequencer did not return to load after the last element")

endmodule
